// ===== design/mazs_pkg.sv =====
// Shared constants, types and command/status structs for the magnetometer averager.
package mazs_pkg;

   // Axis count and field widths
   localparam int AXES        = 3;
   localparam int AXIS_W      = 2;
   localparam int RAW_W       = 13;
   localparam int DIFF_W      = 14;
   localparam int DIFF_MAG_W  = DIFF_W - 1;
   localparam int FIELD_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int GAIN_RESET  = 16384;

   // Count-to-milligauss scale: diff * 8100 * gain / 2^25
   localparam int SCALE_NUM   = 8100;
   localparam int SCALED_W    = 26;
   localparam int FIELD_SHIFT = 25;
   localparam int FIELD_MAX   = 32767;
   localparam int FIELD_MIN_MAG = 32768;

   // Samples per block
   localparam int AVG_COUNT_DEFAULT = 10;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_GAIN_X = 2'd0,
      REG_GAIN_Y = 2'd1,
      REG_GAIN_Z = 2'd2
   } reg_idx_type;

   // Input opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ZERO   = 1'b1;

   localparam logic [AXIS_W-1:0] AXIS_FIRST = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(AXES - 1);

   typedef logic [GAIN_W-1:0] gain_type;
   typedef gain_type [AXES-1:0] gains_type;

   // Datapath phases, one shared multiplier pass per phase where needed
   typedef enum logic [2:0] {
      PH_DIV,
      PH_DIFF,
      PH_SCALE,
      PH_GAIN,
      PH_SAT
   } phase_type;

   typedef struct packed {
      logic              take;
      logic              calc;
      phase_type         phase;
      logic [AXIS_W-1:0] axis;
      logic              finish;
   } cmd_type;

   typedef struct packed {
      logic block_end;
      logic out_free;
   } status_type;

endpackage

// ===== design/mazs_csr.sv =====
// Gain register file behind the APB-style configuration port.
module mazs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mazs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mazs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mazs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output mazs_pkg::gains_type            gains
);
   import mazs_pkg::*;

   gains_type   gain_ff;
   gains_type   gain_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign gains   = gain_ff;

   // Decode the write; drop writes beyond the last register
   always_comb begin
      gain_in = gain_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_X: gain_in[0] = pwdata[GAIN_W-1:0];
            REG_GAIN_Y: gain_in[1] = pwdata[GAIN_W-1:0];
            REG_GAIN_Z: gain_in[2] = pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed gain
   always_comb begin
      unique case (reg_idx)
         REG_GAIN_X: prdata = CSR_DATA_W'(gain_ff[0]);
         REG_GAIN_Y: prdata = CSR_DATA_W'(gain_ff[1]);
         REG_GAIN_Z: prdata = CSR_DATA_W'(gain_ff[2]);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            gain_ff[i] <= GAIN_W'(GAIN_RESET);
         end
      end else begin
         gain_ff <= gain_in;
      end
   end

endmodule

// ===== design/mazs_ctrl.sv =====
// Controller: input handshake and the per-axis phase sequence of the block result.
module mazs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mazs_pkg::status_type status,
   output mazs_pkg::cmd_type    cmd
);
   import mazs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_WAIT
   } state_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && (state_ff == ST_IDLE);

   assign cmd.take   = take;
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.phase  = phase_ff;
   assign cmd.axis   = axis_ff;
   assign cmd.finish = (state_ff == ST_WAIT) && status.out_free;

   // Advance through five phases per axis, then hand the result over
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && status.block_end) begin
               state_in = ST_CALC;
               phase_in = PH_DIV;
               axis_in  = AXIS_FIRST;
            end
         end
         ST_CALC: begin
            unique case (phase_ff)
               PH_DIV:   phase_in = PH_DIFF;
               PH_DIFF:  phase_in = PH_SCALE;
               PH_SCALE: phase_in = PH_GAIN;
               PH_GAIN:  phase_in = PH_SAT;
               PH_SAT: begin
                  phase_in = PH_DIV;
                  if (axis_ff == AXIS_LAST) begin
                     state_in = ST_WAIT;
                  end else begin
                     axis_in = axis_ff + AXIS_W'(1);
                  end
               end
               default: phase_in = PH_DIV;
            endcase
         end
         ST_WAIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DIV;
         axis_ff  <= AXIS_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

// ===== design/mazs_dpath.sv =====
// Datapath: block sums, zero offsets, shared multiplier and the output register.
module mazs_dpath #(
   parameter int AVG_COUNT = mazs_pkg::AVG_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_op,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_x,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_y,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_z,
   input  mazs_pkg::gains_type                 gains,
   input  mazs_pkg::cmd_type                   cmd,
   output mazs_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_x,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_y,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_z,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_x_mg,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_y_mg,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_z_mg
);
   import mazs_pkg::*;

   // Sum and counter widths follow the block length
   localparam int SUM_W   = RAW_W + $clog2(AVG_COUNT);
   localparam int CNT_W   = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
   // Reciprocal for the exact truncating divide by the block length
   localparam int DIV_SHIFT = SUM_W + $clog2(AVG_COUNT) + 1;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
   // Shared multiplier operands
   localparam int MUL_A_W = (SUM_W > SCALED_W) ? SUM_W : SCALED_W;
   localparam int MUL_B_W = (RECIP_W > GAIN_W) ? RECIP_W : GAIN_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MAG_W   = PROD_W - FIELD_SHIFT;

   logic [RAW_W-1:0]   raw [AXES];
   logic [SUM_W-1:0]   sum_ff [AXES];
   logic [SUM_W-1:0]   sum_in [AXES];
   logic [RAW_W-1:0]   offset_ff [AXES];
   logic [RAW_W-1:0]   offset_in [AXES];
   logic               pending_ff, pending_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               last_sample;
   logic               take_sample;

   logic [PROD_W-1:0]  prod_ff;
   logic               neg_ff;
   logic [DIFF_W-1:0]  diff_ff [AXES];
   logic [FIELD_W-1:0] field_ff [AXES];
   logic               rsp_valid_ff;

   logic [SUM_W-1:0]      sum_sel, sum_abs;
   logic [DIFF_W-1:0]     diff_sel, diff_neg;
   logic [DIFF_MAG_W-1:0] diff_abs;
   logic [RAW_W-1:0]      quot;
   logic [DIFF_W-1:0]     avg_pos, avg_val, diff_new;
   logic [MAG_W-1:0]      mag_hi;
   logic [FIELD_W-1:0]    field_new;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     prod_in;

   assign raw[0] = req_raw_x;
   assign raw[1] = req_raw_y;
   assign raw[2] = req_raw_z;

   assign last_sample      = (count_ff == CNT_W'(AVG_COUNT - 1));
   assign take_sample      = cmd.take && (req_op == OP_SAMPLE);
   assign status.block_end = (req_op == OP_SAMPLE) && last_sample;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Accumulate samples, capture offsets and arm zero requests
   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      for (int i = 0; i < AXES; i++) begin
         sum_in[i]    = sum_ff[i];
         offset_in[i] = offset_ff[i];
      end
      if (cmd.take && (req_op == OP_ZERO)) begin
         pending_in = 1'b1;
      end
      if (take_sample) begin
         for (int i = 0; i < AXES; i++) begin
            sum_in[i] = sum_ff[i] + {{(SUM_W - RAW_W){raw[i][RAW_W-1]}}, raw[i]};
         end
         count_in = last_sample ? '0 : count_ff + CNT_W'(1);
         if (last_sample && pending_ff) begin
            for (int i = 0; i < AXES; i++) begin
               offset_in[i] = raw[i];
            end
            pending_in = 1'b0;
         end
      end
      if (cmd.finish) begin
         for (int i = 0; i < AXES; i++) begin
            sum_in[i] = '0;
         end
      end
   end

   // Magnitudes of the selected axis
   assign sum_sel  = sum_ff[cmd.axis];
   assign sum_abs  = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;
   assign diff_sel = diff_ff[cmd.axis];
   assign diff_neg = ~diff_sel + DIFF_W'(1);
   assign diff_abs = diff_sel[DIFF_W-1] ? diff_neg[DIFF_MAG_W-1:0]
                                        : diff_sel[DIFF_MAG_W-1:0];

   // Quotient, sign restore and offset subtract
   assign quot     = prod_ff[DIV_SHIFT +: RAW_W];
   assign avg_pos  = {1'b0, quot};
   assign avg_val  = neg_ff ? (~avg_pos + DIFF_W'(1)) : avg_pos;
   assign diff_new = avg_val - {offset_ff[cmd.axis][RAW_W-1], offset_ff[cmd.axis]};

   // Truncate the scaled product and saturate to 16 bits
   assign mag_hi = prod_ff[PROD_W-1:FIELD_SHIFT];
   always_comb begin
      if (diff_sel[DIFF_W-1]) begin
         if (mag_hi > MAG_W'(FIELD_MIN_MAG)) begin
            field_new = FIELD_W'(FIELD_MIN_MAG);
         end else begin
            field_new = ~mag_hi[FIELD_W-1:0] + FIELD_W'(1);
         end
      end else begin
         if (mag_hi > MAG_W'(FIELD_MAX)) begin
            field_new = FIELD_W'(FIELD_MAX);
         end else begin
            field_new = mag_hi[FIELD_W-1:0];
         end
      end
   end

   // Select the shared multiplier operands by phase
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.phase)
         PH_DIV: begin
            mul_a = MUL_A_W'(sum_abs);
            mul_b = MUL_B_W'(RECIP);
         end
         PH_SCALE: begin
            mul_a = MUL_A_W'(diff_abs);
            mul_b = MUL_B_W'(SCALE_NUM);
         end
         PH_GAIN: begin
            mul_a = MUL_A_W'(prod_ff[SCALED_W-1:0]);
            mul_b = MUL_B_W'(gains[cmd.axis]);
         end
         default: ;
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i]    <= '0;
            offset_ff[i] <= '0;
         end
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         offset_ff  <= offset_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Step the per-axis working registers
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         case (cmd.phase)
            PH_DIV: begin
               prod_ff <= prod_in;
               neg_ff  <= sum_sel[SUM_W-1];
            end
            PH_DIFF:  diff_ff[cmd.axis] <= diff_new;
            PH_SCALE: prod_ff <= prod_in;
            PH_GAIN:  prod_ff <= prod_in;
            PH_SAT:   field_ff[cmd.axis] <= field_new;
            default: ;
         endcase
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_diff_x     <= diff_ff[0];
         rsp_diff_y     <= diff_ff[1];
         rsp_diff_z     <= diff_ff[2];
         rsp_field_x_mg <= field_ff[0];
         rsp_field_y_mg <= field_ff[1];
         rsp_field_z_mg <= field_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/magnetometer_average_zero_scale_top.sv =====
// Top level of the block-averaging magnetometer front end with zero offset and gain.
// Each accepted raw sample item (op 0) is added into per-axis block sums, and a zero
// request item (op 1) arms an offset capture. The sample that completes a block of
// AVG_COUNT samples starts the result computation: one shared multiplier takes each
// axis through five phases (divide by reciprocal, subtract offset, scale by 8100,
// apply gain, truncate and saturate), and the input stalls while this runs and while
// the result register waits on rsp_stall. The result register lets new samples in
// while a finished result still waits to be taken. Gains sit at byte addresses 0, 4
// and 8 and reset to 16384 (a gain of 1.0).
module magnetometer_average_zero_scale_top #(
   parameter int AVG_COUNT = mazs_pkg::AVG_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_x,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_y,
   input  logic signed [mazs_pkg::RAW_W-1:0]   req_raw_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_x,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_y,
   output logic signed [mazs_pkg::DIFF_W-1:0]  rsp_diff_z,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_x_mg,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_y_mg,
   output logic signed [mazs_pkg::FIELD_W-1:0] rsp_field_z_mg,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mazs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mazs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mazs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import mazs_pkg::*;

   gains_type  gains;
   cmd_type    cmd;
   status_type status;

   mazs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   mazs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mazs_dpath #(
      .AVG_COUNT (AVG_COUNT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_raw_z      (req_raw_z),
      .gains          (gains),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_diff_x     (rsp_diff_x),
      .rsp_diff_y     (rsp_diff_y),
      .rsp_diff_z     (rsp_diff_z),
      .rsp_field_x_mg (rsp_field_x_mg),
      .rsp_field_y_mg (rsp_field_y_mg),
      .rsp_field_z_mg (rsp_field_z_mg)
   );

endmodule

// ===== dv/magnetometer_average_zero_scale_top_test.sv =====
// Self-checking testbench for the magnetometer block averager with zero offset and gain.
module magnetometer_average_zero_scale_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mazs_pkg::*;

   localparam int BLOCK_LEN      = 10;
   localparam longint MG_NUM     = 8100;
   localparam int MG_SHIFT       = 25;
   localparam int RUN_LIMIT      = 400000;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 317;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;

   // Register map, byte address is four times the index
   localparam int GAIN_X_IDX = int'(REG_GAIN_X);
   localparam int GAIN_Y_IDX = int'(REG_GAIN_Y);
   localparam int GAIN_Z_IDX = int'(REG_GAIN_Z);
   localparam int SPARE_IDX  = 3;

   typedef enum int {STY_SPREAD, STY_FLAT, STY_EDGE} blk_style_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_TOGGLE} rx_mode_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0]  diff_x;
      logic signed [DIFF_W-1:0]  diff_y;
      logic signed [DIFF_W-1:0]  diff_z;
      logic signed [FIELD_W-1:0] field_x;
      logic signed [FIELD_W-1:0] field_y;
      logic signed [FIELD_W-1:0] field_z;
   } mag_block_type;

   typedef struct packed {
      logic                    op;
      logic signed [RAW_W-1:0] x;
      logic signed [RAW_W-1:0] y;
      logic signed [RAW_W-1:0] z;
      int                      reps;
      bit                      typed;
      int                      dx;
      int                      dy;
      int                      dz;
      int                      fx;
      int                      fy;
      int                      fz;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_op;
   logic signed [RAW_W-1:0]    req_raw_x;
   logic signed [RAW_W-1:0]    req_raw_y;
   logic signed [RAW_W-1:0]    req_raw_z;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [DIFF_W-1:0]   rsp_diff_x;
   logic signed [DIFF_W-1:0]   rsp_diff_y;
   logic signed [DIFF_W-1:0]   rsp_diff_z;
   logic signed [FIELD_W-1:0]  rsp_field_x_mg;
   logic signed [FIELD_W-1:0]  rsp_field_y_mg;
   logic signed [FIELD_W-1:0]  rsp_field_z_mg;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_W-1:0]      paddr;
   logic [CSR_DATA_W-1:0]      pwdata;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // Predictor state: block sums, offsets, armed capture and gains
   int  axis_sum [3]   = '{0, 0, 0};
   int  samples_in     = 0;
   int  zero_off [3]   = '{0, 0, 0};
   bit  zero_armed     = 1'b0;
   int  gain_now [3]   = '{16384, 16384, 16384};

   mag_block_type blocks_due [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            hold_asks      = 0;

   magnetometer_average_zero_scale_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_raw_z      (req_raw_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_diff_x     (rsp_diff_x),
      .rsp_diff_y     (rsp_diff_y),
      .rsp_diff_z     (rsp_diff_z),
      .rsp_field_x_mg (rsp_field_x_mg),
      .rsp_field_y_mg (rsp_field_y_mg),
      .rsp_field_z_mg (rsp_field_z_mg),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #1 clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic match_field(input string name, input int got, input int want);
      if (got != want)
         flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // Scale counts to milligauss, truncate toward zero, saturate to 16 bits
   function automatic int field_of(input int diff, input int gain);
      longint mag;
      longint prod;
      mag  = longint'((diff < 0) ? -diff : diff);
      prod = (mag * MG_NUM * longint'(gain)) >>> MG_SHIFT;
      if (diff < 0) prod = -prod;
      if (prod > 32767) prod = 32767;
      if (prod < -32768) prod = -32768;
      return int'(prod);
   endfunction

   // Fold one accepted item into the block state; flag a finished block
   task automatic fold_sample(input logic op, input logic signed [RAW_W-1:0] x,
                              input logic signed [RAW_W-1:0] y,
                              input logic signed [RAW_W-1:0] z,
                              output bit made, output mag_block_type res);
      int raw [3];
      int d [3];
      int f [3];
      made = 1'b0;
      res  = '0;
      if (op == OP_ZERO) begin
         zero_armed = 1'b1;
      end else begin
         raw[0] = int'(x);
         raw[1] = int'(y);
         raw[2] = int'(z);
         for (int a = 0; a < 3; a++) axis_sum[a] += raw[a];
         samples_in++;
         if (samples_in == BLOCK_LEN) begin
            // capture uses the completing sample, and this block already sees it
            if (zero_armed) begin
               zero_off   = raw;
               zero_armed = 1'b0;
            end
            for (int a = 0; a < 3; a++) begin
               d[a] = axis_sum[a] / BLOCK_LEN - zero_off[a];
               f[a] = field_of(d[a], gain_now[a]);
               axis_sum[a] = 0;
            end
            samples_in  = 0;
            res.diff_x  = DIFF_W'(d[0]);
            res.diff_y  = DIFF_W'(d[1]);
            res.diff_z  = DIFF_W'(d[2]);
            res.field_x = FIELD_W'(f[0]);
            res.field_y = FIELD_W'(f[1]);
            res.field_z = FIELD_W'(f[2]);
            made = 1'b1;
         end
      end
   endtask

   // Offer one item and hold it until accepted
   task automatic offer(input logic op, input logic signed [RAW_W-1:0] x,
                        input logic signed [RAW_W-1:0] y,
                        input logic signed [RAW_W-1:0] z,
                        output bit made, output mag_block_type res);
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_raw_x <= x;
      req_raw_y <= y;
      req_raw_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_sample(op, x, y, z, made, res);
   endtask

   // Drop valid with junk on the payload
   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_op    <= 1'($urandom);
         req_raw_x <= RAW_W'($urandom);
         req_raw_y <= RAW_W'($urandom);
         req_raw_z <= RAW_W'($urandom);
      end
   endtask

   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(input int idx, output logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * idx);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Read back all three gains against the predictor's copy
   task automatic check_gains();
      logic [CSR_DATA_W-1:0] rd;
      for (int a = GAIN_X_IDX; a <= GAIN_Z_IDX; a++) begin
         csr_read(a, rd);
         if (rd !== CSR_DATA_W'(gain_now[a]))
            flag_mismatch($sformatf("gain %0d read %0h want %0h", a, rd, gain_now[a]));
      end
   endtask

   task automatic load_gains(input int gx, input int gy, input int gz);
      csr_write(GAIN_X_IDX, CSR_DATA_W'(gx));
      csr_write(GAIN_Y_IDX, CSR_DATA_W'(gy));
      csr_write(GAIN_Z_IDX, CSR_DATA_W'(gz));
      // writes past the last register must change nothing
      csr_write(SPARE_IDX, CSR_DATA_W'($urandom_range(0, 65535)));
      gain_now[0] = gx;
      gain_now[1] = gy;
      gain_now[2] = gz;
      check_gains();
   endtask

   // Let every due result drain, then let the datapath settle
   task automatic wait_quiet();
      while (blocks_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [RAW_W-1:0] pick_raw(input blk_style_type style,
                                                        input logic signed [RAW_W-1:0] flat);
      logic signed [RAW_W-1:0] v;
      case (style)
         STY_FLAT: v = flat;
         STY_EDGE: begin
            case ($urandom_range(0, 4))
               0: v = RAW_W'(-4096);
               1: v = RAW_W'(2047);
               2: v = RAW_W'(-1);
               3: v = '0;
               default: v = RAW_W'(1);
            endcase
         end
         default: v = RAW_W'($urandom);
      endcase
      return v;
   endfunction

   // Random items in bursts; a block style is picked as each block opens
   task automatic random_run(input int n_items);
      int                      burst;
      blk_style_type           style;
      logic signed [RAW_W-1:0] flat [3];
      logic                    op;
      logic signed [RAW_W-1:0] x;
      logic signed [RAW_W-1:0] y;
      logic signed [RAW_W-1:0] z;
      bit                      made;
      mag_block_type           res;
      burst = 0;
      style = STY_SPREAD;
      flat  = '{default: '0};
      for (int i = 0; i < n_items; i++) begin
         if (burst == 0) begin
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst = $urandom_range(1, 40);
         end
         burst--;
         op = ($urandom_range(0, 24) == 0) ? OP_ZERO : OP_SAMPLE;
         if (op == OP_SAMPLE && samples_in == 0) begin
            case ($urandom_range(0, 3))
               0: style = STY_FLAT;
               1: style = STY_EDGE;
               default: style = STY_SPREAD;
            endcase
            for (int a = 0; a < 3; a++) flat[a] = pick_raw(STY_EDGE, '0);
            if ($urandom_range(0, 1) == 0) flat[$urandom_range(0, 2)] = RAW_W'($urandom);
         end
         if (op == OP_SAMPLE) begin
            x = pick_raw(style, flat[0]);
            y = pick_raw(style, flat[1]);
            z = pick_raw(style, flat[2]);
         end else begin
            x = RAW_W'($urandom);
            y = RAW_W'($urandom);
            z = RAW_W'($urandom);
         end
         offer(op, x, y, z, made, res);
         if (made) blocks_due.push_back(res);
      end
      idle_for(1);
   endtask

   // Receiver: stall on a pattern that changes mode, with a long hold on request
   initial begin
      rx_mode_type mode;
      int          left;
      int          hold_left;
      int          holds_seen;
      mode       = RX_OPEN;
      left       = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_asks) begin
            holds_seen = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
         end else begin
            left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               RX_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
               RX_CHOKE:  rsp_stall <= ($urandom_range(0, 7) != 0);
               RX_TOGGLE: rsp_stall <= ~rsp_stall;
               default:   rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Compare each taken result with the oldest expected block
   always @(posedge clock) begin
      mag_block_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blocks_due.size() == 0) begin
            flag_mismatch("result with no block expected");
         end else begin
            want = blocks_due.pop_front();
            match_field("diff_x", int'(rsp_diff_x), int'(want.diff_x));
            match_field("diff_y", int'(rsp_diff_y), int'(want.diff_y));
            match_field("diff_z", int'(rsp_diff_z), int'(want.diff_z));
            match_field("field_x_mg", int'(rsp_field_x_mg), int'(want.field_x));
            match_field("field_y_mg", int'(rsp_field_y_mg), int'(want.field_y));
            match_field("field_z_mg", int'(rsp_field_z_mg), int'(want.field_z));
         end
      end
   end

   initial begin
      plan_row_type  warmup_plan [4];
      int            gain_sets [PHASES][3];
      bit            made;
      mag_block_type res;
      mag_block_type typed_res;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = OP_SAMPLE;
      req_raw_x = '0;
      req_raw_y = '0;
      req_raw_z = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;

      // Extremes at unity gain, odd truncation, repeated zero request, capture
      warmup_plan = '{
         '{OP_SAMPLE, 2047, -4096, -1, 10, 1'b1, 2047, -4096, -1, 8096, -16200, -3},
         '{OP_ZERO, -4096, 2047, -1, 2, 1'b0, 0, 0, 0, 0, 0, 0},
         '{OP_SAMPLE, 2047, -4096, 0, 9, 1'b0, 0, 0, 0, 0, 0, 0},
         '{OP_SAMPLE, -4096, 2047, 0, 1, 1'b0, 0, 0, 0, 0, 0, 0}
      };

      gain_sets = '{
         '{65535, 0, 1},
         '{0, 1, 65535},
         '{32768, 49152, 8192},
         '{0, 0, 0},
         '{0, 0, 0},
         '{0, 0, 0}
      };
      for (int p = 3; p < PHASES; p++)
         for (int a = 0; a < 3; a++) gain_sets[p][a] = $urandom_range(0, 65535);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Gains come out of reset at unity
      check_gains();

      foreach (warmup_plan[r]) begin
         for (int k = 0; k < warmup_plan[r].reps; k++) begin
            offer(warmup_plan[r].op, warmup_plan[r].x, warmup_plan[r].y,
                  warmup_plan[r].z, made, res);
            if (made) begin
               if (warmup_plan[r].typed && k == warmup_plan[r].reps - 1) begin
                  typed_res.diff_x  = DIFF_W'(warmup_plan[r].dx);
                  typed_res.diff_y  = DIFF_W'(warmup_plan[r].dy);
                  typed_res.diff_z  = DIFF_W'(warmup_plan[r].dz);
                  typed_res.field_x = FIELD_W'(warmup_plan[r].fx);
                  typed_res.field_y = FIELD_W'(warmup_plan[r].fy);
                  typed_res.field_z = FIELD_W'(warmup_plan[r].fz);
                  blocks_due.push_back(typed_res);
               end else begin
                  blocks_due.push_back(res);
               end
            end
         end
      end
      idle_for(1);

      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         load_gains(gain_sets[p][0], gain_sets[p][1], gain_sets[p][2]);
         // hold the receiver off so the block backs up into its input
         if (p == 1 || p == 4) hold_asks++;
         random_run(ITEMS_PER_PHASE);
      end

      while (blocks_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
